[hdl/rotated_notched_square_hit_test_defines.svh]
// Assertion macros shared by the hit test checker.
`ifndef ROTATED_NOTCHED_SQUARE_HIT_TEST_DEFINES_SVH
`define ROTATED_NOTCHED_SQUARE_HIT_TEST_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define RNSQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define RNSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rnsq_pkg.sv]
// Shared widths, register codes and stage types of the hit test block.
package rnsq_pkg;

    localparam int COORD_WIDTH    = 16;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int TRIG_WIDTH     = TRIG_FRAC_BITS + 2;

    localparam int DIFF_W = COORD_WIDTH + 1;          // point minus center
    localparam int PROD_W = DIFF_W + TRIG_WIDTH;      // one rotation product
    localparam int XY_W   = PROD_W + 2;               // doubled rotated coordinate
    localparam int CMP_W  = PROD_W + 4;               // headroom for x-y and 2h terms

    localparam int IN_TDATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = (COORD_WIDTH > TRIG_WIDTH) ? COORD_WIDTH : TRIG_WIDTH;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X    = 4'd0,
        REG_CENTER_Y    = 4'd1,
        REG_COS_ANGLE   = 4'd2,
        REG_SIN_ANGLE   = 4'd3,
        REG_SIDE_LENGTH = 4'd4,
        REG_NOTCH_SIZE  = 4'd5,
        REG_UPPER_CUT   = 4'd6,
        REG_LOWER_CUT   = 4'd7
    } cfg_idx_t;

    // Four rotation products of one point, as queued between front and back.
    typedef struct packed {
        logic signed [PROD_W-1:0] dx_c;
        logic signed [PROD_W-1:0] dy_s;
        logic signed [PROD_W-1:0] dy_c;
        logic signed [PROD_W-1:0] dx_s;
    } prod_t;

    // Figure geometry as seen by the back end.
    typedef struct packed {
        logic [COORD_WIDTH-1:0] side_length;
        logic [COORD_WIDTH-1:0] notch_size;
        logic [COORD_WIDTH-1:0] upper_corner_cut;
        logic [COORD_WIDTH-1:0] lower_corner_cut;
    } shape_t;

endpackage

[hdl/rnsq_front.sv]
// Front end: takes points, offsets by the center and forms the rotation products.
module rnsq_front (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic signed [rnsq_pkg::COORD_WIDTH-1:0]   point_x,
    input  logic signed [rnsq_pkg::COORD_WIDTH-1:0]   point_y,
    input  logic signed [rnsq_pkg::COORD_WIDTH-1:0]   center_x,
    input  logic signed [rnsq_pkg::COORD_WIDTH-1:0]   center_y,
    input  logic signed [rnsq_pkg::TRIG_WIDTH-1:0]    cos_angle,
    input  logic signed [rnsq_pkg::TRIG_WIDTH-1:0]    sin_angle,
    input  logic                                      pop,
    output logic                                      push,
    output rnsq_pkg::prod_t                           push_data
);
    import rnsq_pkg::*;

    logic                      s1_valid_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic signed [DIFF_W-1:0]  dx_next, dy_next;
    logic                      p_valid_reg;
    prod_t                     prod_reg, prod_next;
    logic [CNT_W-1:0]          credit_reg, credit_next;
    logic                      accept;

    // credit counts items in these two stages plus those in the queue
    assign s_tready    = (credit_reg < CNT_W'(FIFO_DEPTH));
    assign accept      = s_tvalid && s_tready;
    assign credit_next = credit_reg + CNT_W'(accept) - CNT_W'(pop);

    always_comb begin
        dx_next = DIFF_W'(point_x) - DIFF_W'(center_x);
        dy_next = DIFF_W'(point_y) - DIFF_W'(center_y);
        prod_next.dx_c = dx_reg * cos_angle;
        prod_next.dy_s = dy_reg * sin_angle;
        prod_next.dy_c = dy_reg * cos_angle;
        prod_next.dx_s = dx_reg * sin_angle;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            credit_reg   <= '0;
        end else begin
            s1_valid_reg <= accept;
            p_valid_reg  <= s1_valid_reg;
            credit_reg   <= credit_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        prod_reg <= prod_next;
    end

    assign push      = p_valid_reg;
    assign push_data = prod_reg;

endmodule

[hdl/rnsq_fifo.sv]
// Short queue of rotation products between front and back ends.
module rnsq_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  rnsq_pkg::prod_t push_data,
    input  logic            pop,
    output logic            not_empty,
    output rnsq_pkg::prod_t head_data
);
    import rnsq_pkg::*;

    prod_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    // the front holds a credit for every entry, so a push never meets a full queue
    assign count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    assign not_empty  = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/rnsq_back.sv]
// Back end: sums the products and tests the rotated point against the figure.
module rnsq_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  rnsq_pkg::prod_t q_data,
    output logic            pop,
    input  rnsq_pkg::shape_t shape,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic            inside_res
);
    import rnsq_pkg::*;

    logic                    a_valid_reg;
    logic signed [XY_W-1:0]  x_reg, y_reg;
    logic signed [XY_W-1:0]  sum_x, sum_y;
    logic                    out_valid_reg;
    logic                    inside_reg, inside_next;
    logic                    out_load, a_load;

    logic signed [CMP_W-1:0] x, y, h, n_half, n_full, u_full, l_full;
    logic                    out_sq, in_notch, in_upper, in_lower;

    // two-stage pipeline with ready chained back from the output register
    assign out_load = !out_valid_reg || m_tready;
    assign a_load   = !a_valid_reg || out_load;
    assign pop      = q_valid && a_load;

    always_comb begin
        sum_x = XY_W'(q_data.dx_c) + XY_W'(q_data.dy_s);
        sum_y = XY_W'(q_data.dy_c) - XY_W'(q_data.dx_s);
    end

    // working scale 2^(F+1): H is side/2
    always_comb begin
        x      = CMP_W'(x_reg);
        y      = CMP_W'(y_reg);
        h      = CMP_W'(shape.side_length)      <<< TRIG_FRAC_BITS;
        n_half = CMP_W'(shape.notch_size)       <<< TRIG_FRAC_BITS;
        n_full = CMP_W'(shape.notch_size)       <<< (TRIG_FRAC_BITS + 1);
        u_full = CMP_W'(shape.upper_corner_cut) <<< (TRIG_FRAC_BITS + 1);
        l_full = CMP_W'(shape.lower_corner_cut) <<< (TRIG_FRAC_BITS + 1);

        out_sq   = (x > h) || (x < -h) || (y > h) || (y < -h);
        in_notch = (x > h - n_full) && (y > -n_half) && (y < n_half);
        in_upper = (x <= u_full - h) && (y >= h - u_full) &&
                   ((x - y) < u_full - (h <<< 1));
        in_lower = (x <= l_full - h) && (y <= l_full - h) &&
                   ((x + y) < l_full - (h <<< 1));

        inside_next = !(out_sq || in_notch || in_upper || in_lower);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (a_load) begin
                a_valid_reg <= q_valid;
            end
            if (out_load) begin
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            x_reg <= sum_x <<< 1;
            y_reg <= sum_y <<< 1;
        end
        if (out_load && a_valid_reg) begin
            inside_reg <= inside_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign inside_res = inside_reg;

endmodule

[hdl/rotated_notched_square_hit_test.sv]
// Rotated notched square hit test: one point in, one inside/outside flag out.
// Each point is moved relative to the configured center, rotated by the Q1.14
// cosine and sine, and tested exactly against a square with a notch in its right
// edge and two diagonal cuts on its left corners (boundaries count as inside).
// Throughput is one point per clock while the output is not stalled. The front
// end (center offset, then four 17x16 multipliers) holds a credit for every
// point until the back end takes it from a four-entry queue, so the input
// only stalls once four points sit between the input port and the back end.
// The back end sums the products, runs the comparisons, and holds the flag in
// an output register. Configuration writes are always accepted; change
// registers only while no point is in flight.
module rotated_notched_square_hit_test (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input points
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [rnsq_pkg::IN_TDATA_W-1:0]       s_tdata,   // point_x, point_y
    // results
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [rnsq_pkg::OUT_TDATA_W-1:0]      m_tdata,   // inside_res, zero pad
    // register writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rnsq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rnsq_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import rnsq_pkg::*;

    logic signed [COORD_WIDTH-1:0] center_x_reg, center_x_next;
    logic signed [COORD_WIDTH-1:0] center_y_reg, center_y_next;
    logic signed [TRIG_WIDTH-1:0]  cos_angle_reg, cos_angle_next;
    logic signed [TRIG_WIDTH-1:0]  sin_angle_reg, sin_angle_next;
    shape_t                        shape_reg, shape_next;

    logic                          push, pop, q_valid, inside_res;
    prod_t                         push_data, head_data;

    // register file: one transfer writes one register, unknown indexes dropped
    assign cfg_ready = 1'b1;

    always_comb begin
        center_x_next  = center_x_reg;
        center_y_next  = center_y_reg;
        cos_angle_next = cos_angle_reg;
        sin_angle_next = sin_angle_reg;
        shape_next     = shape_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_CENTER_X:    center_x_next  = cfg_data[COORD_WIDTH-1:0];
                REG_CENTER_Y:    center_y_next  = cfg_data[COORD_WIDTH-1:0];
                REG_COS_ANGLE:   cos_angle_next = cfg_data[TRIG_WIDTH-1:0];
                REG_SIN_ANGLE:   sin_angle_next = cfg_data[TRIG_WIDTH-1:0];
                REG_SIDE_LENGTH: shape_next.side_length      = cfg_data[COORD_WIDTH-1:0];
                REG_NOTCH_SIZE:  shape_next.notch_size       = cfg_data[COORD_WIDTH-1:0];
                REG_UPPER_CUT:   shape_next.upper_corner_cut = cfg_data[COORD_WIDTH-1:0];
                REG_LOWER_CUT:   shape_next.lower_corner_cut = cfg_data[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            cos_angle_reg <= TRIG_WIDTH'(1) <<< TRIG_FRAC_BITS;   // angle zero
            sin_angle_reg <= '0;
            shape_reg     <= '0;
        end else begin
            center_x_reg  <= center_x_next;
            center_y_reg  <= center_y_next;
            cos_angle_reg <= cos_angle_next;
            sin_angle_reg <= sin_angle_next;
            shape_reg     <= shape_next;
        end
    end

    rnsq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .point_x   (s_tdata[COORD_WIDTH-1:0]),
        .point_y   (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .cos_angle (cos_angle_reg),
        .sin_angle (sin_angle_reg),
        .pop       (pop),
        .push      (push),
        .push_data (push_data)
    );

    rnsq_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .not_empty (q_valid),
        .head_data (head_data)
    );

    rnsq_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_data     (head_data),
        .pop        (pop),
        .shape      (shape_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .inside_res (inside_res)
    );

    assign m_tdata = {(OUT_TDATA_W-1)'(0), inside_res};

endmodule

[hdl/rnsq_checker.sv]
// Port-level checks of the hit test block, bound to its top level.
`include "rotated_notched_square_hit_test_defines.svh"

module rnsq_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic [rnsq_pkg::IN_TDATA_W-1:0]       s_tdata,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [rnsq_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready,
    input logic [rnsq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input logic [rnsq_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import rnsq_pkg::*;

    logic in_xfer;
    logic unused_ok;

    assign in_xfer   = s_tvalid && s_tready;
    assign unused_ok = ^{s_tdata, cfg_index, cfg_data};

    // a stalled result keeps its flag
    `RNSQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    // the input closes only right after taking a point
    `RNSQ_ASSERT_NOW(a_in_close, $fell(s_tready), $past(in_xfer), "s_tready dropped without an input transfer")
    // register writes never wait
    `RNSQ_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready, "register write stalled")
    // only the flag bit of the result carries data
    `RNSQ_ASSERT_NOW(a_out_pad, m_tvalid || unused_ok || !unused_ok, m_tdata[OUT_TDATA_W-1:1] == '0, "result padding not zero")

endmodule

bind rotated_notched_square_hit_test rnsq_checker u_rnsq_checker (.*);
